[rtl/lsqc_pkg.sv]
// ----------------------------------------------------------------------------
// lsqc_pkg
// Shared types and codes for the load-slice queue classifier.
// ----------------------------------------------------------------------------
package lsqc_pkg;

  localparam int unsigned RegBits = 9;
  localparam logic [RegBits-1:0] RegAbsent = 9'd256;

  typedef enum logic [1:0] {
    MODE_UPDATE  = 2'd0,
    MODE_PREDICT = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2,
    MEM_RSVD  = 2'd3
  } mem_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_MARK,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load_item;   // capture the input item
    logic       start_clear; // reset clear counter
    logic       clear_step;  // invalidate one producer entry
    logic       read_step;   // advance slot, write or read producer entry
    logic       mark_step;   // insert the looked-up producer into the set
    logic       load_out;    // latch the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic read_last;
    logic is_predict;
    logic is_update;
    logic is_clear;
  } dp_sts_t;

endpackage

[rtl/lsqc_if.sv]
// ----------------------------------------------------------------------------
// lsqc_in_if / lsqc_out_if
// Valid/ready channels for the classifier items.
// ----------------------------------------------------------------------------
interface lsqc_in_if #(
  parameter int unsigned IP_BITS = 48
);
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [IP_BITS-1:0] ip;
  logic [1:0]         mem_kind;
  logic               is_barrier;
  logic               steered_queue;
  logic [8:0]         src_a;
  logic [8:0]         src_b;
  logic [8:0]         src_c;
  logic [8:0]         dst_a;
  logic [8:0]         dst_b;
  logic [8:0]         addr_a;
  logic [8:0]         addr_b;

  modport source (output valid, mode, ip, mem_kind, is_barrier, steered_queue,
                  src_a, src_b, src_c, dst_a, dst_b, addr_a, addr_b, input ready);
  modport sink   (input valid, mode, ip, mem_kind, is_barrier, steered_queue,
                  src_a, src_b, src_c, dst_a, dst_b, addr_a, addr_b, output ready);
endinterface

interface lsqc_out_if;
  logic valid;
  logic ready;
  logic queue_choice;
  logic set_overflow;

  modport source (output valid, queue_choice, set_overflow, input ready);
  modport sink   (input valid, queue_choice, set_overflow, output ready);
endinterface

[rtl/lsqc_ram.sv]
// ----------------------------------------------------------------------------
// lsqc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lsqc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/lsqc_ctrl.sv]
// ----------------------------------------------------------------------------
// lsqc_ctrl
// Sequencer: capture item, clear sweep or register-slot walk, deliver result.
// ----------------------------------------------------------------------------
module lsqc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lsqc_pkg::dp_cmd_t cmd_o,
  input  lsqc_pkg::dp_sts_t sts_i
);
  import lsqc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // entered from idle on capture: decide on mode
        if (sts_i.is_clear) begin
          cmd_o.start_clear = 1'b1;
          state_d = ST_CLEAR;
        end else if (sts_i.is_update) begin
          cmd_o.read_step = 1'b1;
          state_d = ST_MARK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = ST_DONE;
      end
      ST_MARK: begin
        // producer entry of the last-read slot is now at the RAM output
        cmd_o.mark_step = 1'b1;
        if (sts_i.read_last) state_d = ST_DONE;
        else cmd_o.read_step = 1'b1;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // an offered result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q);

  // items are only taken while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE));

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |-> in_valid_i);

  // result register is never overwritten while still offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i));
endmodule

[rtl/lsqc_dp.sv]
// ----------------------------------------------------------------------------
// lsqc_dp
// Producer table RAM, valid bits, marked-address CAM and result register.
// ----------------------------------------------------------------------------
module lsqc_dp #(
  parameter int unsigned NUM_REGS    = 256,
  parameter int unsigned SET_ENTRIES = 128,
  parameter int unsigned IP_BITS     = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsqc_pkg::dp_cmd_t  cmd_i,
  output lsqc_pkg::dp_sts_t  sts_o,
  input  logic [1:0]         mode_i,
  input  logic [IP_BITS-1:0] ip_i,
  input  logic [1:0]         mem_kind_i,
  input  logic               is_barrier_i,
  input  logic               steered_queue_i,
  input  logic [8:0]         src_a_i,
  input  logic [8:0]         src_b_i,
  input  logic [8:0]         src_c_i,
  input  logic [8:0]         dst_a_i,
  input  logic [8:0]         dst_b_i,
  input  logic [8:0]         addr_a_i,
  input  logic [8:0]         addr_b_i,
  output logic               queue_choice_o,
  output logic               set_overflow_o
);
  import lsqc_pkg::*;

  localparam int unsigned RegIdx = $clog2(NUM_REGS);
  localparam int unsigned SetIdx = $clog2(SET_ENTRIES);
  localparam int unsigned CntW   = $clog2(SET_ENTRIES + 1);
  localparam int unsigned NumSlots = 5; // dst a, dst b, then sources or address regs
  localparam int unsigned SlotW  = 3;

  // captured item
  mode_e              mode_q;
  logic [IP_BITS-1:0] ip_q;
  logic               memop_q, load_q, barrier_q, mark_src_q;
  logic [8:0]         reg_q [NumSlots];

  // walk state
  logic [SlotW-1:0]   slot_q;
  logic               rd_ok_q;
  logic [RegIdx:0]    clr_q;

  // producer table
  logic [NUM_REGS-1:0] pvalid_q;
  logic [IP_BITS-1:0]  pram_rdata;
  logic                pram_we;
  logic [RegIdx-1:0]   pram_waddr, pram_raddr;

  // marked set
  logic [SET_ENTRIES-1:0] svalid_q;
  logic [IP_BITS-1:0]     sip_q [SET_ENTRIES];
  logic [CntW-1:0]        count_q;

  logic over_q, choice_q, over_acc_q;

  function automatic logic reg_ok(input logic [8:0] r);
    return (r != RegAbsent) && ({23'd0, r} < NUM_REGS);
  endfunction

  // per slot: slots 0,1 write destinations (non-memory ops), 2..4 read
  logic [8:0] cur_reg;
  logic       cur_wr, cur_rd;
  assign cur_reg = reg_q[slot_q];
  always_comb begin
    cur_wr = 1'b0;
    cur_rd = 1'b0;
    if (slot_q < SlotW'(2)) begin
      cur_wr = !memop_q && reg_ok(cur_reg);
    end else begin
      cur_rd = reg_ok(cur_reg) && (memop_q || mark_src_q);
    end
  end

  assign pram_we    = cmd_i.read_step && cur_wr;
  assign pram_waddr = RegIdx'(cur_reg);
  assign pram_raddr = RegIdx'(cur_reg);

  lsqc_ram #(.WIDTH(IP_BITS), .DEPTH(NUM_REGS)) u_prod (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .waddr_i (pram_waddr),
    .wdata_i (ip_q),
    .raddr_i (pram_raddr),
    .rdata_o (pram_rdata)
  );

  // CAM match of an address against the set
  function automatic logic set_hit(input logic [IP_BITS-1:0] a,
                                   input logic [SET_ENTRIES-1:0] v,
                                   input logic [IP_BITS-1:0] s [SET_ENTRIES]);
    logic h;
    h = 1'b0;
    for (int i = 0; i < SET_ENTRIES; i++) begin
      if (v[i] && s[i] == a) h = 1'b1;
    end
    return h;
  endfunction

  logic [SetIdx-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = SET_ENTRIES - 1; i >= 0; i--) begin
      if (!svalid_q[i]) free_idx = SetIdx'(i);
    end
  end

  logic mark_hit, pred_hit;
  assign mark_hit = set_hit(pram_rdata, svalid_q, sip_q);
  assign pred_hit = set_hit(ip_q, svalid_q, sip_q);

  logic do_mark;
  assign do_mark = cmd_i.mark_step && rd_ok_q && !mark_hit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q     <= mode_e'(mode_i);
      ip_q       <= ip_i;
      memop_q    <= (mem_kind_i == MEM_LOAD) || (mem_kind_i == MEM_STORE);
      load_q     <= (mem_kind_i == MEM_LOAD);
      barrier_q  <= is_barrier_i;
      mark_src_q <= steered_queue_i && !is_barrier_i;
      reg_q[0]   <= dst_a_i;
      reg_q[1]   <= dst_b_i;
      if ((mem_kind_i == MEM_LOAD) || (mem_kind_i == MEM_STORE)) begin
        reg_q[2] <= addr_a_i;
        reg_q[3] <= addr_b_i;
        reg_q[4] <= RegAbsent;
      end else begin
        reg_q[2] <= src_a_i;
        reg_q[3] <= src_b_i;
        reg_q[4] <= src_c_i;
      end
    end
    if (do_mark && (count_q < CntW'(SET_ENTRIES))) begin
      sip_q[free_idx] <= pram_rdata;
    end
    if (cmd_i.load_out) begin
      choice_q <= (mode_q == MODE_PREDICT) && (load_q || barrier_q || pred_hit);
      over_q   <= over_acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      rd_ok_q    <= 1'b0;
      clr_q      <= '0;
      pvalid_q   <= '0;
      svalid_q   <= '0;
      count_q    <= '0;
      over_acc_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        slot_q     <= '0;
        over_acc_q <= 1'b0;
      end
      if (cmd_i.start_clear) clr_q <= '0;
      if (cmd_i.clear_step) begin
        pvalid_q[clr_q[RegIdx-1:0]] <= 1'b0;
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.read_step) begin
        rd_ok_q <= cur_rd && pvalid_q[RegIdx'(cur_reg)];
        slot_q  <= slot_q + 1'b1;
        if (pram_we) pvalid_q[pram_waddr] <= 1'b1;
      end
      if (do_mark) begin
        if (count_q < CntW'(SET_ENTRIES)) begin
          svalid_q[free_idx] <= 1'b1;
          count_q <= count_q + 1'b1;
        end else begin
          over_acc_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.clear_last = (clr_q == (RegIdx+1)'(NUM_REGS - 1));
  assign sts_o.read_last  = (slot_q == SlotW'(NumSlots));
  assign sts_o.is_predict = (mode_q == MODE_PREDICT);
  assign sts_o.is_update  = (mode_q == MODE_UPDATE);
  assign sts_o.is_clear   = (mode_q == MODE_CLEAR);

  assign queue_choice_o = choice_q;
  assign set_overflow_o = over_q;
endmodule

[rtl/load_slice_queue_classifier.sv]
// One item at a time; the next item is accepted in the cycle after the result loads.
// Update walks two destination and three source slots through the producer table
// RAM, one slot per cycle; clear resets the producer valid bits, one entry per cycle;
// predict and the unused mode go straight to the result. A stalled receiver holds
// back the loading of the next result until the offered one is taken.
// Reset: asynchronous active-low; producer table and marked set come up empty.
// ----------------------------------------------------------------------------
// load_slice_queue_classifier
// Backward dependency classifier steering micro-ops to main or bypass queue.
// ----------------------------------------------------------------------------
module load_slice_queue_classifier #(
  parameter int unsigned NUM_REGS    = 256,
  parameter int unsigned SET_ENTRIES = 128,
  parameter int unsigned IP_BITS     = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsqc_in_if.sink     in_i,
  lsqc_out_if.source  out_o
);
  import lsqc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  lsqc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lsqc_dp #(
    .NUM_REGS(NUM_REGS), .SET_ENTRIES(SET_ENTRIES), .IP_BITS(IP_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (in_i.mode),
    .ip_i            (in_i.ip),
    .mem_kind_i      (in_i.mem_kind),
    .is_barrier_i    (in_i.is_barrier),
    .steered_queue_i (in_i.steered_queue),
    .src_a_i         (in_i.src_a),
    .src_b_i         (in_i.src_b),
    .src_c_i         (in_i.src_c),
    .dst_a_i         (in_i.dst_a),
    .dst_b_i         (in_i.dst_b),
    .addr_a_i        (in_i.addr_a),
    .addr_b_i        (in_i.addr_b),
    .queue_choice_o  (out_o.queue_choice),
    .set_overflow_o  (out_o.set_overflow)
  );
endmodule
